// ----- rtl/rgb_hsv_color_converter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RGB/HSV colour converter
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_HSV_COLOR_CONVERTER_ASSERT_SVH
`define RGB_HSV_COLOR_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// check with reset masking
`define RHC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that must also hold around reset
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHC_ASSERT(lbl, clk, rstn, prop, msg)
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants and types of the RGB/HSV colour converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rhc_pkg;
    localparam int CHANNEL_BITS = 8;
    localparam int A_BITS  = 11;
    localparam int BC_BITS = 8;
    localparam int HUE_SHIFT = 8;
    localparam logic [A_BITS-1:0] HUE_GREEN = 11'd512;
    localparam logic [A_BITS-1:0] HUE_BLUE  = 11'd1024;
    localparam logic [A_BITS-1:0] HUE_FULL  = 11'd1536;
    localparam logic [8:0]        HUE_ONE   = 9'd256;

    typedef enum logic [1:0] {
        HC_RED,
        HC_GREEN,
        HC_BLUE
    } hue_case_t;

    typedef struct packed {
        logic      valid;
        logic      mode;
        logic      zero_delta;
        hue_case_t hcase;
        logic      neg;
    } ctl_t;
endpackage
`default_nettype wire

// ----- rtl/rhc_prep.sv -----
// ----------------------------------------------------------------------------
// rhc_prep
// Input stage: clamping, max/min search, divider operands, s*v product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhc_prep #(
    parameter int CW = 8,
    parameter int QB = 9
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         ce,
    input  wire logic                         in_valid,
    input  wire logic                         in_mode,
    input  wire logic [rhc_pkg::A_BITS-1:0]   in_a,
    input  wire logic [rhc_pkg::BC_BITS-1:0]  in_b,
    input  wire logic [rhc_pkg::BC_BITS-1:0]  in_c,
    output rhc_pkg::ctl_t                     ctl,
    output logic [CW-1:0]                     mx,
    output logic [CW-1:0]                     delta,
    output logic [CW+QB-1:0]                  hue_dvd,
    output logic [CW+QB-1:0]                  sat_dvd,
    output logic [2*CW-1:0]                   prod,
    output logic [rhc_pkg::A_BITS-1:0]        hue,
    output logic [CW-1:0]                     val
);
    localparam logic [CW-1:0] CMAX = '1;

    logic [CW+rhc_pkg::A_BITS-1:0]  a_ext;
    logic [CW+rhc_pkg::BC_BITS-1:0] b_ext, c_ext;
    logic [CW-1:0] r, g, b, mx_c, mn_c, p, q, diff, delta_c;
    logic [2*CW-1:0] satn;
    rhc_pkg::ctl_t ctl_next, ctl_reg;
    logic [CW-1:0] mx_reg, delta_reg, v_reg;
    logic [CW+QB-1:0] hue_dvd_reg, sat_dvd_reg;
    logic [2*CW-1:0] prod_reg;
    logic [rhc_pkg::A_BITS-1:0] h_reg;

    always_comb begin
        a_ext = {{CW{1'b0}}, in_a};
        b_ext = {{CW{1'b0}}, in_b};
        c_ext = {{CW{1'b0}}, in_c};
        r = (a_ext > {{rhc_pkg::A_BITS{1'b0}}, CMAX}) ? CMAX : a_ext[CW-1:0];
        g = (b_ext > {{rhc_pkg::BC_BITS{1'b0}}, CMAX}) ? CMAX : b_ext[CW-1:0];
        b = (c_ext > {{rhc_pkg::BC_BITS{1'b0}}, CMAX}) ? CMAX : c_ext[CW-1:0];
        mx_c = r;
        if (g > mx_c) mx_c = g;
        if (b > mx_c) mx_c = b;
        mn_c = r;
        if (g < mn_c) mn_c = g;
        if (b < mn_c) mn_c = b;
        delta_c = mx_c - mn_c;
        ctl_next.valid = in_valid;
        ctl_next.mode = in_mode;
        ctl_next.zero_delta = (delta_c == '0);
        // red wins ties, then green
        if (mx_c == r) begin
            ctl_next.hcase = rhc_pkg::HC_RED;
            p = g;
            q = b;
        end else if (mx_c == g) begin
            ctl_next.hcase = rhc_pkg::HC_GREEN;
            p = b;
            q = r;
        end else begin
            ctl_next.hcase = rhc_pkg::HC_BLUE;
            p = r;
            q = g;
        end
        ctl_next.neg = (p < q);
        diff = ctl_next.neg ? (q - p) : (p - q);
        // delta * CMAX as a shift and subtract
        satn = {delta_c, {CW{1'b0}}} - {{CW{1'b0}}, delta_c};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (ce) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mx_reg      <= mx_c;
            delta_reg   <= delta_c;
            hue_dvd_reg <= (CW+QB)'(diff) << rhc_pkg::HUE_SHIFT;
            sat_dvd_reg <= (CW+QB)'(satn);
            prod_reg    <= {{CW{1'b0}}, g} * {{CW{1'b0}}, b};
            h_reg       <= in_a;
            v_reg       <= b;
        end
    end

    assign ctl     = ctl_reg;
    assign mx      = mx_reg;
    assign delta   = delta_reg;
    assign hue_dvd = hue_dvd_reg;
    assign sat_dvd = sat_dvd_reg;
    assign prod    = prod_reg;
    assign hue     = h_reg;
    assign val     = v_reg;
endmodule
`default_nettype wire

// ----- rtl/rhc_div.sv -----
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhc_div #(
    parameter int DW = 8,
    parameter int QB = 9
) (
    input  wire logic            aclk,
    input  wire logic            ce,
    input  wire logic [DW+QB-1:0] dividend,
    input  wire logic [DW-1:0]   divisor,
    output logic [QB-1:0]        quotient
);
    logic [DW-1:0] rem_reg [1:QB];
    logic [QB-1:0] lo_reg  [1:QB];
    logic [QB-1:0] quo_reg [1:QB];
    logic [DW-1:0] dvs_reg [1:QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW-1:0] rem_in, dvs_in;
        logic [QB-1:0] lo_in, quo_in;
        logic [DW:0] shifted, trial;

        // stage 0 takes the operands; the dividend is below divisor * 2^QB
        if (k == 0) begin : g_first
            assign rem_in = dividend[DW+QB-1:QB];
            assign lo_in  = dividend[QB-1:0];
            assign quo_in = '0;
            assign dvs_in = divisor;
        end else begin : g_next
            assign rem_in = rem_reg[k];
            assign lo_in  = lo_reg[k];
            assign quo_in = quo_reg[k];
            assign dvs_in = dvs_reg[k];
        end

        always_comb begin
            shifted = {rem_in, lo_in[QB-1]};
            trial   = shifted - {1'b0, dvs_in};
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (!trial[DW]) begin
                    rem_reg[k+1] <= trial[DW-1:0];
                    quo_reg[k+1] <= {quo_in[QB-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= shifted[DW-1:0];
                    quo_reg[k+1] <= {quo_in[QB-2:0], 1'b0};
                end
                lo_reg[k+1]  <= {lo_in[QB-2:0], 1'b0};
                dvs_reg[k+1] <= dvs_in;
            end
        end
    end

    assign quotient = quo_reg[QB];
endmodule
`default_nettype wire

// ----- rtl/rhc_hsv.sv -----
// ----------------------------------------------------------------------------
// rhc_hsv
// HSV to RGB datapath in four stages: /CMAX, correction, x and m, sextant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhc_hsv #(
    parameter int CW = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       ce,
    input  wire logic [2*CW-1:0]            prod,
    input  wire logic [rhc_pkg::A_BITS-1:0] hue,
    input  wire logic [CW-1:0]              val,
    output logic [CW-1:0]                   red,
    output logic [CW-1:0]                   green,
    output logic [CW-1:0]                   blue,
    output logic                            err
);
    localparam logic [CW-1:0] CMAX = '1;

    logic [2*CW:0]   q0_sum;
    logic [CW:0]     q0_reg;
    logic [2*CW-1:0] p1_reg;
    logic [rhc_pkg::A_BITS-1:0] h1_reg, h2_reg, h3_reg;
    logic [CW-1:0]   v1_reg, v2_reg;
    logic [2*CW+1:0] rem;
    logic [CW-1:0]   chroma_next, chroma_reg, c3_reg, m3_reg;
    logic [8:0]      hdist, wgt;
    logic [CW+8:0]   px_reg;
    logic [CW-1:0]   x, rr, gg, bb;
    logic [CW:0]     sr, sg, sb;
    logic            err_next;
    logic [CW-1:0]   r_reg, g_reg, b_reg;
    logic            err_reg;

    // q0 = (p + p>>CW) >> CW undershoots p/CMAX by at most one
    assign q0_sum = {1'b0, prod} + {{(CW+1){1'b0}}, prod[2*CW-1:CW]};

    always_ff @(posedge aclk) begin
        if (ce) begin
            q0_reg <= q0_sum[2*CW:CW];
            p1_reg <= prod;
            h1_reg <= hue;
            v1_reg <= val;
        end
    end

    always_comb begin
        rem = {2'b0, p1_reg} - ({1'b0, q0_reg, {CW{1'b0}}} - {{(CW+1){1'b0}}, q0_reg});
        chroma_next = (rem >= {{(CW+2){1'b0}}, CMAX}) ? (q0_reg[CW-1:0] + 1'b1)
                                                      : q0_reg[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            chroma_reg <= chroma_next;
            h2_reg     <= h1_reg;
            v2_reg     <= v1_reg;
        end
    end

    always_comb begin
        hdist = h2_reg[8] ? {1'b0, h2_reg[7:0]} : (rhc_pkg::HUE_ONE - {1'b0, h2_reg[7:0]});
        wgt   = rhc_pkg::HUE_ONE - hdist;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg <= (CW+9)'(chroma_reg) * (CW+9)'(wgt);
            c3_reg <= chroma_reg;
            m3_reg <= v2_reg - chroma_reg;
            h3_reg <= h2_reg;
        end
    end

    always_comb begin
        x = px_reg[CW+7:8];
        err_next = 1'b0;
        case (h3_reg[10:8])
            3'd0: begin rr = c3_reg; gg = x;      bb = '0;     end
            3'd1: begin rr = x;      gg = c3_reg; bb = '0;     end
            3'd2: begin rr = '0;     gg = c3_reg; bb = x;      end
            3'd3: begin rr = '0;     gg = x;      bb = c3_reg; end
            3'd4: begin rr = x;      gg = '0;     bb = c3_reg; end
            3'd5: begin rr = c3_reg; gg = '0;     bb = x;      end
            default: begin
                // out-of-range hue: magenta
                rr = CMAX;
                gg = '0;
                bb = CMAX;
                err_next = 1'b1;
            end
        endcase
        sr = {1'b0, rr} + {1'b0, m3_reg};
        sg = {1'b0, gg} + {1'b0, m3_reg};
        sb = {1'b0, bb} + {1'b0, m3_reg};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r_reg   <= sr[CW] ? CMAX : sr[CW-1:0];
            g_reg   <= sg[CW] ? CMAX : sg[CW-1:0];
            b_reg   <= sb[CW] ? CMAX : sb[CW-1:0];
            err_reg <= err_next;
        end
    end

    assign red   = r_reg;
    assign green = g_reg;
    assign blue  = b_reg;
    assign err   = err_reg;
endmodule
`default_nettype wire

// ----- rtl/rhc_delay.sv -----
// ----------------------------------------------------------------------------
// rhc_delay
// Shift line that keeps side data level with the divider stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rhc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         ce,
    input  wire logic [W-1:0] din,
    output logic [W-1:0]      dout
);
    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) tap_reg[i] <= '0;
        end else if (ce) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule
`default_nettype wire

// ----- rtl/rgb_hsv_color_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter
// Per-pixel RGB to HSV (mode 0) and HSV to RGB (mode 1) converter.
// ----------------------------------------------------------------------------
// Use:
//   s_ channel carries one pixel request per beat; tuser[0] selects the mode.
//   m_ channel returns one result per request, in order; tuser[0] flags a
//   mode 1 hue of 1536 or more (output is then magenta plus m, saturated).
//   Hue is in sextants times 256 (0..1535); channels are fractions of
//   2^CHANNEL_BITS-1.
// Path: an input stage, then the two restoring dividers (one quotient bit per
//   stage, QB = max(9, CHANNEL_BITS)), then an output register to m_tvalid.
// Throughput: one pixel per cycle, except while the pipeline stalls.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
//   s_tready drops in the same cycle, nothing is dropped or repeated.
// Reset: aresetn low clears all valid bits; the block is empty afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_hsv_color_converter_assert.svh"
module rgb_hsv_color_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // in_a[10:0], in_b[18:11], in_c[26:19]
    input  wire logic [0:0]  s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_a[10:0], out_b[18:11], out_c[26:19]
    output logic [0:0]       m_tuser    // hue_error[0]
);
    localparam int CW = rhc_pkg::CHANNEL_BITS;
    localparam int QB = (CW > 9) ? CW : 9;
    localparam int CTL_W = $bits(rhc_pkg::ctl_t);
    localparam logic [CW-1:0] CMAX = '1;

    logic ce;
    rhc_pkg::ctl_t ctl1, ctl_d;
    logic [CW-1:0] mx1, delta1, v1, mx_d;
    logic [CW+QB-1:0] hue_dvd, sat_dvd;
    logic [2*CW-1:0] prod1;
    logic [rhc_pkg::A_BITS-1:0] h1;
    logic [QB-1:0] hue_q, sat_q;
    logic [CW-1:0] hr, hg, hb, hr_d, hg_d, hb_d;
    logic herr, herr_d;
    logic [CTL_W+CW-1:0] side_d;
    logic [3*CW:0] hsv_d;

    logic [rhc_pkg::A_BITS-1:0] hue_next, base;
    logic [8:0] hq;
    logic [CW-1:0] sat_next;
    logic [CW+rhc_pkg::A_BITS-1:0] a_wide;
    logic [CW+rhc_pkg::BC_BITS-1:0] b_wide, c_wide;

    logic m_tvalid_reg;
    logic [rhc_pkg::A_BITS-1:0]  out_a_reg;
    logic [rhc_pkg::BC_BITS-1:0] out_b_reg, out_c_reg;
    logic hue_error_reg, mode_reg;

    assign ce = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    rhc_prep #(.CW(CW), .QB(QB)) u_prep (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_tvalid), .in_mode(s_tuser[0]),
        .in_a(s_tdata[10:0]), .in_b(s_tdata[18:11]), .in_c(s_tdata[26:19]),
        .ctl(ctl1), .mx(mx1), .delta(delta1), .hue_dvd(hue_dvd), .sat_dvd(sat_dvd),
        .prod(prod1), .hue(h1), .val(v1)
    );

    rhc_div #(.DW(CW), .QB(QB)) u_div_hue (
        .aclk(aclk), .ce(ce), .dividend(hue_dvd), .divisor(delta1), .quotient(hue_q)
    );

    rhc_div #(.DW(CW), .QB(QB)) u_div_sat (
        .aclk(aclk), .ce(ce), .dividend(sat_dvd), .divisor(mx1), .quotient(sat_q)
    );

    rhc_delay #(.W(CTL_W + CW), .DEPTH(QB)) u_side_dly (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .din({ctl1, mx1}), .dout(side_d)
    );

    rhc_hsv #(.CW(CW)) u_hsv (
        .aclk(aclk), .ce(ce), .prod(prod1), .hue(h1), .val(v1),
        .red(hr), .green(hg), .blue(hb), .err(herr)
    );

    // hsv path is four stages deep; pad it to the divider depth
    rhc_delay #(.W(3*CW + 1), .DEPTH(QB - 4)) u_hsv_dly (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .din({herr, hr, hg, hb}), .dout(hsv_d)
    );

    always_comb begin
        ctl_d  = rhc_pkg::ctl_t'(side_d[CTL_W+CW-1:CW]);
        mx_d   = side_d[CW-1:0];
        herr_d = hsv_d[3*CW];
        hr_d   = hsv_d[3*CW-1:2*CW];
        hg_d   = hsv_d[2*CW-1:CW];
        hb_d   = hsv_d[CW-1:0];
        hq     = hue_q[8:0];
        case (ctl_d.hcase)
            rhc_pkg::HC_GREEN: base = rhc_pkg::HUE_GREEN;
            rhc_pkg::HC_BLUE:  base = rhc_pkg::HUE_BLUE;
            default:           base = '0;
        endcase
        // negative red hue wraps by a full turn; minus zero stays zero
        if (ctl_d.zero_delta)
            hue_next = '0;
        else if (!ctl_d.neg)
            hue_next = base + {2'b0, hq};
        else if (ctl_d.hcase == rhc_pkg::HC_RED)
            hue_next = (hq == '0) ? '0 : (rhc_pkg::HUE_FULL - {2'b0, hq});
        else
            hue_next = base - {2'b0, hq};
        sat_next = ctl_d.zero_delta ? '0 : sat_q[CW-1:0];
        if (ctl_d.mode) begin
            a_wide = {{rhc_pkg::A_BITS{1'b0}}, hr_d};
            b_wide = {{rhc_pkg::BC_BITS{1'b0}}, hg_d};
            c_wide = {{rhc_pkg::BC_BITS{1'b0}}, hb_d};
        end else begin
            a_wide = {{CW{1'b0}}, hue_next};
            b_wide = {{rhc_pkg::BC_BITS{1'b0}}, sat_next};
            c_wide = {{rhc_pkg::BC_BITS{1'b0}}, mx_d};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= ctl_d.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_a_reg     <= a_wide[rhc_pkg::A_BITS-1:0];
            out_b_reg     <= b_wide[rhc_pkg::BC_BITS-1:0];
            out_c_reg     <= c_wide[rhc_pkg::BC_BITS-1:0];
            hue_error_reg <= ctl_d.mode && herr_d;
            mode_reg      <= ctl_d.mode;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_c_reg, out_b_reg, out_a_reg};
    assign m_tuser  = hue_error_reg;

    logic [CW+rhc_pkg::BC_BITS-1:0] cmax_wide;
    assign cmax_wide = {{rhc_pkg::BC_BITS{1'b0}}, CMAX};

    `RHC_ASSERT(a_hue_range, aclk, aresetn, m_tvalid && !mode_reg |-> out_a_reg < rhc_pkg::HUE_FULL && !hue_error_reg, "rgb to hsv hue out of range or flagged")
    `RHC_ASSERT(a_err_magenta, aclk, aresetn, m_tvalid && hue_error_reg |-> out_c_reg == cmax_wide[rhc_pkg::BC_BITS-1:0] && mode_reg, "hue error without saturated blue")
    `RHC_ASSERT(a_sat_le_max, aclk, aresetn, m_tvalid && !mode_reg |-> out_b_reg <= cmax_wide[rhc_pkg::BC_BITS-1:0], "saturation above full scale")
    `RHC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid straight after reset")
endmodule
`default_nettype wire
